[rtl/core/led_frame_pattern_sequencer_unit_defines.svh]
// assertion macros for the led frame pattern sequencer
// expects signals named clock and reset in the module that uses them
`ifndef LED_FRAME_PATTERN_SEQUENCER_UNIT_DEFINES_SVH
`define LED_FRAME_PATTERN_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LFPS_ASSERT_NOW(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define LFPS_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

[rtl/core/lfps_pkg.sv]
// shared types and constants of the led frame pattern sequencer
// no dependencies
package lfps_pkg;

   localparam int PATTERN_DEPTH = 1024;
   localparam int ADDR_W        = $clog2(PATTERN_DEPTH);
   localparam int WIDE_W        = 18;

   localparam int OP_W       = 2;
   localparam int ENTRY_AW   = 10;
   localparam int ENTRY_W    = 8;
   localparam int LED_W      = 5;
   localparam int LPF_W      = 6;
   localparam int HOLD_W     = 8;
   localparam int PAUSE_W    = 16;
   localparam int LEN_W      = 11;
   localparam int SCAN_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [LPF_W-1:0]   MAX_FRAME    = LPF_W'(32);
   localparam logic [ENTRY_W-1:0] DARK_CODE    = ENTRY_W'(32);
   localparam int                 HOLD_SHIFT   = 3;
   localparam logic [PAUSE_W-1:0] PAUSE_RESET  = PAUSE_W'(24);
   localparam logic [LEN_W-1:0]   LENGTH_RESET = LEN_W'(32);

   typedef enum logic [OP_W-1:0] {
      OP_TICK    = 2'd0,
      OP_WRITE   = 2'd1,
      OP_RESTART = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LEDS_PER_FRAME = 2'd0,
      REG_FRAME_HOLD     = 2'd1,
      REG_DEFAULT_PAUSE  = 2'd2,
      REG_PATTERN_LENGTH = 2'd3
   } reg_index_type;

   // what a tick leaves for the readout stage
   typedef struct packed {
      logic led_valid;
      logic in_range;
      logic switched;
   } lookup_type;

endpackage

[rtl/core/lfps_if.sv]
// request and response channel interfaces of the led frame pattern sequencer
// depends on lfps_pkg
interface lfps_req_if
   import lfps_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [ENTRY_AW-1:0] entry_address;
   logic [ENTRY_W-1:0]  entry_value;

   modport source (output valid, operation, entry_address, entry_value, input ready);
   modport sink   (input valid, operation, entry_address, entry_value, output ready);
endinterface

interface lfps_rsp_if
   import lfps_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             led_valid;
   logic [LED_W-1:0] led_number;
   logic             led_dark;
   logic             frame_switched;

   modport source (output valid, led_valid, led_number, led_dark, frame_switched,
                   input ready);
   modport sink   (input valid, led_valid, led_number, led_dark, frame_switched,
                   output ready);
endinterface

[rtl/core/led_frame_pattern_sequencer_unit.sv]
// top level of the led frame pattern sequencer
// depends on lfps_pkg, lfps_if, lfps_ram, lfps_ctrl, lfps_out and the defines header
//
//   channel  | dir | carries
//   ---------+-----+----------------------------------------------
//   req      | in  | operation, entry_address, entry_value
//   rsp      | out | led_valid, led_number, led_dark, frame_switched
//   csr      | in  | write enable, register index, write data
//
// one word is taken per cycle until a stalled rsp fills the readout stage
// each result passes the pattern memory read at the accept edge, then the output register
// reset is synchronous; the pattern memory is not cleared and needs no sweep
// a stalled rsp holds the output word while one more word waits in the readout stage
`include "led_frame_pattern_sequencer_unit_defines.svh"

module led_frame_pattern_sequencer_unit
   import lfps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   lfps_req_if.sink              req,
   lfps_rsp_if.source            rsp,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   logic               accept;
   logic               take_ready;
   logic               mem_write_enable;
   logic [ADDR_W-1:0]  mem_write_address;
   logic [ENTRY_W-1:0] mem_write_data;
   logic               mem_read_enable;
   logic [ADDR_W-1:0]  mem_read_address;
   logic [ENTRY_W-1:0] mem_read_data;
   lookup_type         lookup;

   assign req.ready = take_ready;
   assign accept    = req.valid && take_ready;

   lfps_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .accept            (accept),
      .operation         (req.operation),
      .entry_address     (req.entry_address),
      .entry_value       (req.entry_value),
      .mem_write_enable  (mem_write_enable),
      .mem_write_address (mem_write_address),
      .mem_write_data    (mem_write_data),
      .mem_read_enable   (mem_read_enable),
      .mem_read_address  (mem_read_address),
      .lookup            (lookup)
   );

   lfps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PATTERN_DEPTH)
   ) u_pattern_ram (
      .clock         (clock),
      .write_enable  (mem_write_enable),
      .write_address (mem_write_address),
      .write_data    (mem_write_data),
      .read_enable   (mem_read_enable),
      .read_address  (mem_read_address),
      .read_data     (mem_read_data)
   );

   lfps_out u_out (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .lookup        (lookup),
      .mem_read_data (mem_read_data),
      .take_ready    (take_ready),
      .rsp           (rsp)
   );

   `LFPS_ASSERT_NOW(a_dark_has_no_number, rsp.valid && rsp.led_dark,
                    rsp.led_number == '0, "dark word carries an led number")
   `LFPS_ASSERT_NOW(a_idle_word_blank, rsp.valid && !rsp.led_valid,
                    !rsp.led_dark && !rsp.frame_switched, "blank word has flags set")
   `LFPS_ASSERT_NOW(a_switch_lights, rsp.valid && rsp.frame_switched, rsp.led_valid,
                    "frame switch without a scanned entry")
   `LFPS_ASSERT_NOW(a_ready_when_out_free, !rsp.valid, req.ready,
                    "input blocked while output register is free")
   // an accepted word reaches rsp past the readout stage, or an older word still holds it
   `LFPS_ASSERT_NEXT(a_accept_fills_pipe, $past(accept && !reset), rsp.valid,
                     "accepted word vanished")

endmodule

[rtl/core/lfps_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module lfps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

[rtl/core/lfps_ctrl.sv]
// sequencing state, config registers and pattern memory addressing
// depends on lfps_pkg
module lfps_ctrl
   import lfps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  accept,
   input  logic [OP_W-1:0]       operation,
   input  logic [ENTRY_AW-1:0]   entry_address,
   input  logic [ENTRY_W-1:0]    entry_value,
   output logic                  mem_write_enable,
   output logic [ADDR_W-1:0]     mem_write_address,
   output logic [ENTRY_W-1:0]    mem_write_data,
   output logic                  mem_read_enable,
   output logic [ADDR_W-1:0]     mem_read_address,
   output lookup_type            lookup
);

   logic [LPF_W-1:0]   lpf_ff;
   logic [HOLD_W-1:0]  hold_ff;
   logic [PAUSE_W-1:0] pause_ff;
   logic [LEN_W-1:0]   length_ff;

   logic [LEN_W-1:0]   next_start_ff,   next_start_in;
   logic [LEN_W-1:0]   active_start_ff, active_start_in;
   logic               pending_ff,      pending_in;
   logic               present_ff,      present_in;
   logic [SCAN_W-1:0]  scan_ff,         scan_in;
   logic [PAUSE_W-1:0] timer_ff,        timer_in;

   logic [LPF_W-1:0]   frame_size;
   logic               is_tick;
   logic               fire;
   logic [LEN_W:0]     start_sum;
   logic [LEN_W-1:0]   next_start_a;
   logic [PAUSE_W-1:0] reload;
   logic [PAUSE_W-1:0] timer_a;
   logic               pending_a;
   logic               switched;
   logic [LEN_W:0]     index;
   logic [WIDE_W-1:0]  index_wide;
   logic [WIDE_W-1:0]  write_wide;
   logic               in_range;
   logic [SCAN_W:0]    scan_inc;
   op_type             op;

   always_ff @(posedge clock) begin
      if (reset) begin
         lpf_ff    <= LPF_W'(1);
         hold_ff   <= '0;
         pause_ff  <= PAUSE_RESET;
         length_ff <= LENGTH_RESET;
      end else if (csr_write_enable) begin
         case (reg_index_type'(csr_index))
            REG_LEDS_PER_FRAME: lpf_ff    <= csr_write_data[LPF_W-1:0];
            REG_FRAME_HOLD:     hold_ff   <= csr_write_data[HOLD_W-1:0];
            REG_DEFAULT_PAUSE:  pause_ff  <= csr_write_data[PAUSE_W-1:0];
            REG_PATTERN_LENGTH: length_ff <= csr_write_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      op      = op_type'(operation);
      is_tick = accept && (op == OP_TICK);

      if (lpf_ff == '0) begin
         frame_size = LPF_W'(1);
      end else if (lpf_ff > MAX_FRAME) begin
         frame_size = MAX_FRAME;
      end else begin
         frame_size = lpf_ff;
      end

      // new frame start and timer reload once the timer has run out
      fire      = (timer_ff == '0) && !pending_ff;
      start_sum = {1'b0, next_start_ff} + (LEN_W+1)'(frame_size);
      reload    = (hold_ff != '0) ? (PAUSE_W'(hold_ff) << HOLD_SHIFT) : pause_ff;
      if (fire) begin
         next_start_a = (start_sum < {1'b0, length_ff}) ? start_sum[LEN_W-1:0] : '0;
         timer_a      = reload;
      end else begin
         next_start_a = next_start_ff;
         timer_a      = timer_ff;
      end
      pending_a = pending_ff || fire;

      // pending frame only takes over at scan position zero
      switched        = pending_a && (scan_ff == '0);
      active_start_in = switched ? next_start_a : active_start_ff;
      present_in      = present_ff || switched;

      index      = {1'b0, active_start_in} + (LEN_W+1)'(scan_ff);
      index_wide = WIDE_W'(index);
      in_range   = (index < {1'b0, length_ff}) && (index_wide < WIDE_W'(PATTERN_DEPTH));

      scan_inc = {1'b0, scan_ff} + (SCAN_W+1)'(1);
      if (present_in) begin
         scan_in = (scan_inc >= (SCAN_W+1)'(frame_size)) ? '0 : scan_inc[SCAN_W-1:0];
      end else begin
         scan_in = scan_ff;
      end

      timer_in      = (timer_a != '0) ? (timer_a - PAUSE_W'(1)) : '0;
      next_start_in = next_start_a;
      pending_in    = pending_a && !switched;

      write_wide = WIDE_W'(entry_address);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_start_ff   <= LENGTH_RESET;
         active_start_ff <= '0;
         pending_ff      <= 1'b0;
         present_ff      <= 1'b0;
         scan_ff         <= '0;
         timer_ff        <= '0;
      end else if (accept && (op == OP_RESTART)) begin
         next_start_ff <= length_ff;
         timer_ff      <= '0;
         pending_ff    <= 1'b0;
      end else if (is_tick) begin
         next_start_ff   <= next_start_in;
         active_start_ff <= active_start_in;
         pending_ff      <= pending_in;
         present_ff      <= present_in;
         scan_ff         <= scan_in;
         timer_ff        <= timer_in;
      end
   end

   // write lands at the accept edge, so a later tick reads it back directly
   assign mem_write_enable  = accept && (op == OP_WRITE) &&
                              (write_wide < WIDE_W'(PATTERN_DEPTH));
   assign mem_write_address = write_wide[ADDR_W-1:0];
   assign mem_write_data    = entry_value;
   assign mem_read_enable   = is_tick && present_in && in_range;
   assign mem_read_address  = index_wide[ADDR_W-1:0];

   assign lookup.led_valid = is_tick && present_in;
   assign lookup.in_range  = in_range;
   assign lookup.switched  = is_tick && switched;

endmodule

[rtl/core/lfps_out.sv]
// readout stage behind the pattern memory and the response output register
// depends on lfps_pkg and lfps_if
module lfps_out
   import lfps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  lookup_type         lookup,
   input  logic [ENTRY_W-1:0] mem_read_data,
   output logic               take_ready,
   lfps_rsp_if.source         rsp
);

   logic             s1_valid_ff,  s1_valid_in;
   lookup_type       s1_lookup_ff;
   logic             out_valid_ff, out_valid_in;
   logic             led_valid_ff;
   logic [LED_W-1:0] led_number_ff;
   logic             led_dark_ff;
   logic             switched_ff;

   logic             s1_advance;
   logic             dark;

   always_comb begin
      s1_advance   = s1_valid_ff && (!out_valid_ff || rsp.ready);
      take_ready   = !s1_valid_ff || s1_advance;
      s1_valid_in  = accept || (s1_valid_ff && !s1_advance);
      out_valid_in = s1_advance || (out_valid_ff && !rsp.ready);
      dark         = !s1_lookup_ff.in_range || (mem_read_data >= DARK_CODE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_lookup_ff <= lookup;
      end
      if (s1_advance) begin
         led_valid_ff  <= s1_lookup_ff.led_valid;
         led_dark_ff   <= s1_lookup_ff.led_valid && dark;
         led_number_ff <= (s1_lookup_ff.led_valid && !dark) ? mem_read_data[LED_W-1:0] : '0;
         switched_ff   <= s1_lookup_ff.switched;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.led_valid      = led_valid_ff;
   assign rsp.led_number     = led_number_ff;
   assign rsp.led_dark       = led_dark_ff;
   assign rsp.frame_switched = switched_ff;

endmodule
